FILE: sv/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types, constants and the priority compare for the max-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 16;
    localparam int FIELD_W   = 16;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = ADDR_W + 2;
    localparam int REC_W     = 3 * FIELD_W;

    localparam logic [63:0]        KEY_MASK64 = (64'd1 << KEY_WIDTH) - 64'd1;
    localparam logic [FIELD_W-1:0] KEY_MASK   = KEY_MASK64[FIELD_W-1:0];

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2
    } t_op;

    // tag sits in the low bits so the struct lines up with tdata
    typedef struct packed {
        logic [FIELD_W-1:0] score;
        logic [FIELD_W-1:0] ident;
        logic [FIELD_W-1:0] tag;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;      // input beat taken
        logic drop;        // push against a full queue
        logic push_start;  // place new record in the hole at the tail
        logic pop_start;   // shrink count, read last record
        logic rd_parent;   // read parent of hole
        logic up_move;     // parent moves down into hole
        logic wr_mov;      // moving record settles at hole
        logic pop_load;    // last record becomes the moving record, hole at root
        logic rd_children; // read both children of hole
        logic dn_move;     // better child moves up into hole
        logic out_load;    // capture result beat
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_one;
        logic pos_zero;
        logic left_out;
        logic up_win;
        logic dn_win;
    } t_status;

    // higher score first, lower ident on a tie
    function automatic logic outranks(t_rec x, t_rec y);
        logic res;
        if (x.score != y.score) begin
            res = (x.score > y.score);
        end else begin
            res = (x.ident < y.ident);
        end
        return res;
    endfunction

endpackage

FILE: sv/mpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_dp
// Heap memory, hole position, moving record, count, top copy and result register.
// ----------------------------------------------------------------------------
module mpq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpq_pkg::t_cmd     i_cmd,
    input  mpq_pkg::t_rec     i_rec,
    output mpq_pkg::t_status  o_status,
    output mpq_pkg::t_rec     o_out_rec,
    output logic              o_out_empty,
    output logic              o_out_drop
);
    import mpq_pkg::*;

    t_rec             r_mem [CAPACITY];
    logic [CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_pos;
    t_rec             r_mov;
    t_rec             r_top;
    t_rec             r_rd_a;
    t_rec             r_rd_b;
    logic             r_drop;
    t_rec             r_out;
    logic             r_out_empty;
    logic             r_out_drop;

    logic [ADDR_W-1:0] w_parent;
    logic [ADDR_W-1:0] w_pos_dec;
    logic [IDX_W-1:0]  w_left;
    logic [IDX_W-1:0]  w_right;
    logic [CNT_W-1:0]  w_cnt_dec;
    logic              w_right_win;
    t_rec              w_best;
    logic [ADDR_W-1:0] w_best_idx;
    logic [ADDR_W-1:0] w_addr_a;
    logic              w_rd_a_en;
    logic              w_wr_en;
    t_rec              w_wr_data;
    t_rec              w_push_rec;
    logic              w_empty;

    assign w_pos_dec  = r_pos - ADDR_W'(1);
    assign w_parent   = w_pos_dec >> 1;
    assign w_left     = (IDX_W'(r_pos) << 1) + IDX_W'(1);
    assign w_right    = w_left + IDX_W'(1);
    assign w_cnt_dec  = r_cnt - CNT_W'(1);
    assign w_empty    = (r_cnt == '0);

    assign w_right_win = (w_right < IDX_W'(r_cnt)) && outranks(r_rd_b, r_rd_a);
    assign w_best      = w_right_win ? r_rd_b : r_rd_a;
    assign w_best_idx  = w_right_win ? w_right[ADDR_W-1:0] : w_left[ADDR_W-1:0];

    always_comb begin
        w_push_rec       = i_rec;
        w_push_rec.ident = i_rec.ident & KEY_MASK;
        w_push_rec.score = i_rec.score & KEY_MASK;
    end

    always_comb begin
        priority if (i_cmd.pop_start) begin
            w_addr_a = w_cnt_dec[ADDR_W-1:0];
        end else if (i_cmd.rd_parent) begin
            w_addr_a = w_parent;
        end else begin
            w_addr_a = w_left[ADDR_W-1:0];
        end
    end

    assign w_rd_a_en = i_cmd.pop_start | i_cmd.rd_parent | i_cmd.rd_children;
    assign w_wr_en   = i_cmd.up_move | i_cmd.dn_move | i_cmd.wr_mov;

    always_comb begin
        priority if (i_cmd.up_move) begin
            w_wr_data = r_rd_a;
        end else if (i_cmd.dn_move) begin
            w_wr_data = w_best;
        end else begin
            w_wr_data = r_mov;
        end
    end

    // heap memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (w_rd_a_en) begin
            r_rd_a <= r_mem[w_addr_a];
        end
        if (i_cmd.rd_children) begin
            r_rd_b <= r_mem[w_right[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.push_start) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.pop_start) begin
            r_cnt <= w_cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_start) begin
            r_pos <= r_cnt[ADDR_W-1:0];
            r_mov <= w_push_rec;
        end else if (i_cmd.pop_load) begin
            r_pos <= '0;
            r_mov <= r_rd_a;
        end else if (i_cmd.up_move) begin
            r_pos <= w_parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= w_best_idx;
        end
        // root copy follows every write to slot zero
        if (w_wr_en && (r_pos == '0)) begin
            r_top <= w_wr_data;
        end
        if (i_cmd.accept) begin
            r_drop <= i_cmd.drop;
        end
        if (i_cmd.out_load) begin
            r_out       <= w_empty ? '0 : r_top;
            r_out_empty <= w_empty;
            r_out_drop  <= r_drop;
        end
    end

    assign o_status.full     = (r_cnt == CNT_W'(CAPACITY));
    assign o_status.empty    = w_empty;
    assign o_status.cnt_one  = (r_cnt == CNT_W'(1));
    assign o_status.pos_zero = (r_pos == '0);
    assign o_status.left_out = (w_left >= IDX_W'(r_cnt));
    assign o_status.up_win   = outranks(r_mov, r_rd_a);
    assign o_status.dn_win   = outranks(w_best, r_mov);

    assign o_out_rec   = r_out;
    assign o_out_empty = r_out_empty;
    assign o_out_drop  = r_out_drop;

endmodule

FILE: sv/mpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for push sift-up, pop sift-down and the result handshake.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic [1:0]       i_s_op,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    input  mpq_pkg::t_status i_status,
    output mpq_pkg::t_cmd    o_cmd
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DONE;
                    unique case (t_op'(i_s_op))
                        OP_PUSH: begin
                            if (i_status.full) begin
                                o_cmd.drop = 1'b1;
                            end else begin
                                o_cmd.push_start = 1'b1;
                                n_state          = S_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (!i_status.empty) begin
                                o_cmd.pop_start = 1'b1;
                                if (!i_status.cnt_one) begin
                                    n_state = S_POP_LD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (i_status.pos_zero) begin
                    o_cmd.wr_mov = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status.up_win) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.wr_mov = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_POP_LD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_status.left_out) begin
                    o_cmd.wr_mov = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_children = 1'b1;
                    n_state           = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_status.dn_win) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.wr_mov = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // result register free or draining this cycle
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

FILE: sv/max_priority_queue_with_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_with_tiebreak
// Binary max-heap of {tag, ident, score}; higher score first, lower ident on a
// tie. Each beat pushes, peeks or pops and returns the top record afterward.
//
// Channel  Dir  Handshake              Payload
// s        in   i_s_tvalid/o_s_tready  tdata {tag, ident, score}, tuser op
// m        out  o_m_tvalid/i_m_tready  tdata {tag, ident, score}, tuser flags
//
// Peek or dropped push goes straight to the result. Push or pop takes a read
// and a compare state per heap level, set by the registered heap memory read.
// One beat is worked at a time; a new beat is taken while the last result
// still waits on the master side. Synchronous active-low reset empties the
// queue at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
module max_priority_queue_with_tiebreak (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // payload_tag[15:0], ident[31:16], score[47:32]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // top_tag[15:0], top_ident[31:16], top_score[47:32]
    output logic [1:0]  o_m_tuser    // queue_empty[0], push_dropped[1]
);
    import mpq_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_rec    w_in_rec;
    t_rec    w_out_rec;
    logic    w_out_empty;
    logic    w_out_drop;

    assign w_in_rec = t_rec'(i_s_tdata);

    mpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_s_op    (i_s_tuser),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    mpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rec       (w_in_rec),
        .o_status    (w_status),
        .o_out_rec   (w_out_rec),
        .o_out_empty (w_out_empty),
        .o_out_drop  (w_out_drop)
    );

    assign o_m_tdata = w_out_rec;
    assign o_m_tuser = {w_out_drop, w_out_empty};

endmodule

FILE: tb/mpq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_heap_checker
// Watches both stream channels of the priority queue, keeps its own binary
// max-heap of the accepted records, and compares each result beat with the
// oldest predicted top record. Errors, drops and open predictions go out to
// the testbench top.
// ----------------------------------------------------------------------------
module mpq_heap_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [mpq_pkg::REC_W-1:0] i_s_tdata,   // payload_tag[15:0], ident[31:16], score[47:32]
    input  logic [1:0]                i_s_tuser,   // operation[1:0]
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [mpq_pkg::REC_W-1:0] i_m_tdata,   // top_tag[15:0], top_ident[31:16], top_score[47:32]
    input  logic [1:0]                i_m_tuser,   // queue_empty[0], push_dropped[1]
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_drops
);
    import mpq_pkg::*;

    typedef struct packed {
        logic dropped;
        logic empty;
        t_rec top;
    } t_top_result;

    t_rec        heap_mem [CAPACITY];
    int unsigned heap_cnt;
    t_top_result pending_tops[$];
    int          err_cnt   = 0;
    int          chk_cnt   = 0;
    int          drop_cnt  = 0;
    int          pending_r = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pending_r;
    assign o_checked = chk_cnt;
    assign o_drops   = drop_cnt;

    function automatic logic ranks_above(t_rec x, t_rec y);
        if (x.score != y.score) begin
            return x.score > y.score;
        end
        return x.ident < y.ident;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        t_rec tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    // runs one operation on the model heap, returns the expected result beat
    function automatic t_top_result apply_heap_op(logic [1:0] op, t_rec rec);
        t_top_result res;
        int unsigned pos;
        int unsigned parent;
        int unsigned left;
        int unsigned best;
        logic        done;
        res = '0;
        if (op == OP_PUSH) begin
            if (heap_cnt >= CAPACITY) begin
                res.dropped = 1'b1;
            end else begin
                rec.ident = rec.ident & KEY_MASK;
                rec.score = rec.score & KEY_MASK;
                heap_mem[heap_cnt] = rec;
                pos  = heap_cnt;
                heap_cnt++;
                done = 1'b0;
                while (!done && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (ranks_above(heap_mem[pos], heap_mem[parent])) begin
                        swap_slots(pos, parent);
                        pos = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else if (op == OP_POP) begin
            if (heap_cnt > 0) begin
                heap_cnt--;
                heap_mem[0] = heap_mem[heap_cnt];
                pos  = 0;
                done = 1'b0;
                while (!done) begin
                    left = 2 * pos + 1;
                    if (left >= heap_cnt) begin
                        done = 1'b1;
                    end else begin
                        best = left;
                        // left child wins a tie between children
                        if (left + 1 < heap_cnt &&
                            ranks_above(heap_mem[left + 1], heap_mem[left]))
                            best = left + 1;
                        if (ranks_above(heap_mem[best], heap_mem[pos])) begin
                            swap_slots(pos, best);
                            pos = best;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        // peek and the unused code change nothing
        if (heap_cnt == 0) begin
            res.empty = 1'b1;
        end else begin
            res.top = heap_mem[0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_top_result want;
        t_rec        got;
        if (!i_rst_n) begin
            heap_cnt = 0;
            pending_tops.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                want = apply_heap_op(i_s_tuser, t_rec'(i_s_tdata));
                pending_tops.push_back(want);
                if (want.dropped) drop_cnt++;
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_rec'(i_m_tdata);
                if (pending_tops.size() == 0) begin
                    $error("result beat with no prediction waiting: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    err_cnt++;
                end else begin
                    want = pending_tops.pop_front();
                    chk_cnt++;
                    if (i_m_tuser[0] !== want.empty) begin
                        $error("queue_empty: expected %0d, actual %0d", want.empty, i_m_tuser[0]);
                        err_cnt++;
                    end
                    if (i_m_tuser[1] !== want.dropped) begin
                        $error("push_dropped: expected %0d, actual %0d",
                               want.dropped, i_m_tuser[1]);
                        err_cnt++;
                    end
                    if (got.tag !== want.top.tag) begin
                        $error("top_tag: expected %h, actual %h", want.top.tag, got.tag);
                        err_cnt++;
                    end
                    if (got.ident !== want.top.ident) begin
                        $error("top_ident: expected %h, actual %h", want.top.ident, got.ident);
                        err_cnt++;
                    end
                    if (got.score !== want.top.score) begin
                        $error("top_score: expected %h, actual %h", want.top.score, got.score);
                        err_cnt++;
                    end
                end
            end
        end
        pending_r <= pending_tops.size();
    end

endmodule

FILE: tb/tb_max_priority_queue_with_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_priority_queue_with_tiebreak
// Drives push, peek, pop and the unused operation code into the priority
// queue: a directed opening on empty, tied and extreme records, then random
// phases that fill, drain and churn the heap with random stalls on both
// channels. The checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module tb_max_priority_queue_with_tiebreak;
    import mpq_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS = 1700;
    localparam int         QUIET_TAIL = 200;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_mode;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic [REC_W-1:0] s_tdata   = '0;
    logic [1:0]       s_tuser   = OP_PEEK;
    logic             m_tready  = 1'b1;
    logic             s_tready;
    logic             m_tvalid;
    logic [REC_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    int   n_errors;
    int   n_pending;
    int   n_checked;
    int   n_drops;

    logic tx_idle_en = 1'b0;
    logic rx_idle_en = 1'b0;
    int   stall_cnt  = 0;
    int   op_cnt [4] = '{0, 0, 0, 0};

    max_priority_queue_with_tiebreak uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    mpq_heap_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_checked  (n_checked),
        .o_drops    (n_drops)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls: tready held low while a random stall count runs down
    always @(posedge clk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= (stall_cnt == 1);
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            stall_cnt <= $urandom_range(1, 6);
            m_tready  <= 1'b0;
        end
    end

    // keys lean toward small and edge values so ties and extremes show up
    function automatic logic [FIELD_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return FIELD_W'($urandom_range(0, 7));
            1:       return FIELD_W'($urandom);
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return 16'hFFF8 + FIELD_W'($urandom_range(0, 7));
        endcase
    endfunction

    // called at a clock edge; returns at the edge where the beat is taken
    task automatic send_beat(input logic [1:0] op, input logic [FIELD_W-1:0] tag,
                             input logic [FIELD_W-1:0] ident,
                             input logic [FIELD_W-1:0] score);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {score, ident, tag};
        op_cnt[op]++;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
    endtask

    task automatic send_random(input t_mode mode);
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  op = (r < 80) ? OP_PUSH : (r < 88) ? OP_POP : (r < 96) ? OP_PEEK : OP_UNUSED;
            MODE_DRAIN: op = (r < 15) ? OP_PUSH : (r < 85) ? OP_POP : (r < 96) ? OP_PEEK : OP_UNUSED;
            default:    op = (r < 45) ? OP_PUSH : (r < 85) ? OP_POP : (r < 96) ? OP_PEEK : OP_UNUSED;
        endcase
        send_beat(op, FIELD_W'($urandom), pick_key(), pick_key());
    endtask

    initial begin
        #(64'd10_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int    sent;
        int    len;
        t_mode mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: peek, pop, unused code
        send_beat(OP_PEEK,   16'h1111, 16'h2222, 16'h3333);
        send_beat(OP_POP,    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);
        // extremes and score ties
        send_beat(OP_PUSH,   16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_PUSH,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_PUSH,   16'h1234, 16'h0000, 16'hFFFF);
        send_beat(OP_PUSH,   16'hABCD, 16'h0000, 16'hFFFF);  // same keys, other tag
        send_beat(OP_PUSH,   16'h5555, 16'hAAAA, 16'hAAAA);
        send_beat(OP_PUSH,   16'hAAAA, 16'h5555, 16'h5555);
        send_beat(OP_PEEK,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_POP,    16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_POP,    16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_PUSH,   16'h0007, 16'h0005, 16'h0007);
        send_beat(OP_PUSH,   16'h0003, 16'h0003, 16'h0007);
        send_beat(OP_PUSH,   16'h0009, 16'h0009, 16'h0007);
        repeat (7) send_beat(OP_POP, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_POP,    16'h0000, 16'h0000, 16'h0000);  // pop past empty
        wait_drained();

        // random phases; the first one fills the heap past capacity
        sent = 0;
        mode = MODE_FILL;
        len  = 120;
        while (sent < RAND_ITEMS) begin
            if (RAND_ITEMS - sent <= QUIET_TAIL) begin
                tx_idle_en  = 1'b0;
                rx_idle_en <= 1'b0;
            end else begin
                tx_idle_en  = ($urandom_range(0, 3) != 0);
                rx_idle_en <= ($urandom_range(0, 3) != 0);
            end
            repeat (len) begin
                if (sent < RAND_ITEMS) begin
                    send_random(mode);
                    sent++;
                end
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
            mode = t_mode'($urandom_range(0, 2));
            len  = $urandom_range(20, 120);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("beats sent: %0d push, %0d peek, %0d pop, %0d unused code",
                 op_cnt[OP_PUSH], op_cnt[OP_PEEK], op_cnt[OP_POP], op_cnt[OP_UNUSED]);
        $display("results checked: %0d, pushes dropped on a full heap: %0d",
                 n_checked, n_drops);
        if (n_errors == 0 && n_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mpq_pkg.sv
sv/mpq_dp.sv
sv/mpq_ctrl.sv
sv/max_priority_queue_with_tiebreak.sv
tb/mpq_heap_checker.sv
tb/tb_max_priority_queue_with_tiebreak.sv
